FILE: hdl/mlfe_pkg.sv
// Shared types and constants of the LED fade engine.
// Used by every module of the block; depends on nothing.
package mlfe_pkg;

    // Configuration register indexes
    localparam logic [2:0] REG_DURATION   = 3'd0;
    localparam logic [2:0] REG_MIN_IV     = 3'd1;
    localparam logic [2:0] REG_CHAN_COUNT = 3'd2;
    localparam logic [2:0] REG_CALIB_ONE  = 3'd3;
    localparam logic [2:0] REG_CALIB_TWO  = 3'd4;
    localparam logic [2:0] REG_CALIB_THR  = 3'd5;
    localparam logic [2:0] REG_CALIB_FOUR = 3'd6;

    localparam logic [15:0] DURATION_RESET = 16'd1000;
    localparam logic [15:0] DURATION_FLOOR = 16'd249;
    localparam logic [9:0]  MIN_IV_RESET   = 10'd10;
    localparam logic [2:0]  CHAN_RESET     = 3'd5;
    localparam logic [7:0]  LEVEL_MAX      = 8'd255;

    typedef struct packed {
        logic       mode;
        logic [2:0] channel;
        logic [7:0] level;
    } t_in_item;

    typedef struct packed {
        logic [14:0] pwm_one;
        logic [14:0] pwm_two;
        logic [14:0] pwm_three;
        logic [14:0] pwm_four;
        logic [7:0]  master_now;
        logic        fading;
        logic        outputs_changed;
    } t_out_item;

    typedef enum logic [1:0] {
        CMD_TARGET,
        CMD_IGNORE,
        CMD_TICK
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind  kind;
        logic [2:0] channel;
        logic [7:0] level;
    } t_cmd;

    typedef struct packed {
        logic [15:0]     duration;
        logic [9:0]      min_iv;
        logic [3:0][7:0] calib;
    } t_cfg;

    // Request to the shared restoring divider
    typedef struct packed {
        logic        start;
        logic [15:0] rem0;
        logic [15:0] dnd;
        logic [15:0] den;
        logic [4:0]  steps;
    } t_div_req;

endpackage

FILE: hdl/mlfe_front.sv
// Front end: accepts requests, classifies them and queues them for the engine.
// Depends on mlfe_pkg.
module mlfe_front #(
    parameter int IW = 3
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  mlfe_pkg::t_in_item i_in_item,
    input  logic [IW-1:0]     i_n,
    output logic              o_cmd_vld,
    output mlfe_pkg::t_cmd    o_cmd,
    input  logic              i_cmd_pop
);

    mlfe_pkg::t_cmd r_q [2];
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_cnt;
    mlfe_pkg::t_cmd cmd_in;
    logic           acc;
    logic           pop_ok;

    always_comb begin
        cmd_in.channel = i_in_item.channel;
        cmd_in.level   = i_in_item.level;
        if (i_in_item.mode) begin
            cmd_in.kind = mlfe_pkg::CMD_TICK;
        end else if (int'(i_in_item.channel) < int'(i_n)) begin
            cmd_in.kind = mlfe_pkg::CMD_TARGET;
        end else begin
            cmd_in.kind = mlfe_pkg::CMD_IGNORE;
        end
    end

    assign full      = (r_cnt == 2'd2);
    assign acc       = push && !full;
    assign o_cmd_vld = (r_cnt != 2'd0);
    assign o_cmd     = r_q[r_rp];
    assign pop_ok    = i_cmd_pop && o_cmd_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (acc) begin
                r_q[r_wp] <= cmd_in;
                r_wp      <= !r_wp;
            end
            if (pop_ok) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + {1'b0, acc} - {1'b0, pop_ok};
        end
    end

endmodule

FILE: hdl/mlfe_div.sv
// Restoring divider, one quotient bit per cycle, shared by the engine.
// Depends on mlfe_pkg.
module mlfe_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  mlfe_pkg::t_div_req i_req,
    output logic               o_done,
    output logic [15:0]        o_quo
);

    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_cnt;
    logic [15:0] r_rem;
    logic [15:0] r_dnd;
    logic [15:0] r_den;
    logic [16:0] trial;
    logic [16:0] diff;
    logic        ge;

    assign trial  = {r_rem, r_dnd[15]};
    assign ge     = trial >= {1'b0, r_den};
    assign diff   = trial - {1'b0, r_den};
    assign o_done = r_done;
    assign o_quo  = r_dnd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.steps;
                r_rem  <= i_req.rem0;
                r_dnd  <= i_req.dnd;
                r_den  <= i_req.den;
            end else if (r_busy) begin
                r_rem <= ge ? diff[15:0] : trial[15:0];
                r_dnd <= {r_dnd[14:0], ge};
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

FILE: hdl/mlfe_back.sv
// Back end: fade sequencer that retargets, steps channels and forms PWM values.
// Depends on mlfe_pkg; drives the shared mlfe_div unit.
module mlfe_back #(
    parameter int NUM_CHANNELS = 5,
    parameter int IW           = 3
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cmd_vld,
    input  mlfe_pkg::t_cmd      i_cmd,
    output logic                o_cmd_pop,
    input  mlfe_pkg::t_cfg      i_cfg,
    input  logic [IW-1:0]       i_n,
    output mlfe_pkg::t_div_req  o_div_req,
    input  logic                i_div_done,
    input  logic [15:0]         i_div_quo,
    input  logic                i_out_full,
    output logic                o_res_vld,
    output mlfe_pkg::t_out_item o_res
);

    localparam int CW = $clog2(NUM_CHANNELS);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_DIV_PER,
        S_DIV_TOT,
        S_CH,
        S_CDIV,
        S_PWM_MUL,
        S_PWM_DIV,
        S_PWM_OUT
    } t_state;

    t_state             r_state;
    logic [7:0]         r_cur [NUM_CHANNELS];
    logic [7:0]         r_tgt [NUM_CHANNELS];
    logic [7:0]         r_sta [NUM_CHANNELS];
    logic [15:0]        r_idx;
    logic [15:0]        r_total;
    logic [15:0]        r_iv;
    logic [15:0]        r_tick;
    logic               r_run;
    logic [IW-1:0]      r_i;
    logic [7:0]         r_gap;
    logic               r_neg;
    logic               r_chg;
    logic [15:0]        r_x [4];
    logic [7:0]         r_y [4];
    mlfe_pkg::t_div_req r_div_req;
    logic               r_res_vld;
    mlfe_pkg::t_out_item r_res;

    logic [CW-1:0]      ci;
    logic [CW-1:0]      ch_idx;
    logic [7:0]         cur_i;
    logic [7:0]         tgt_i;
    logic [7:0]         sta_i;
    logic               i_lt_n;
    logic [7:0]         absgap;
    logic               dneg;
    logic [7:0]         mag;
    logic [23:0]        prod;
    logic [15:0]        min_iv;
    logic [15:0]        tick_n;
    logic [9:0]         nv_add;
    logic [9:0]         nv_sub;
    logic [7:0]         nv;
    logic [7:0]         cur_pad [5];
    logic [7:0]         master;
    logic [15:0]        x_pwm [4];
    logic [7:0]         y_pwm [4];
    logic [16:0]        q0s;
    logic [7:0]         q0;
    logic [16:0]        rem;

    assign ci     = r_i[CW-1:0];
    assign ch_idx = CW'(i_cmd.channel);
    assign cur_i  = r_cur[ci];
    assign tgt_i  = r_tgt[ci];
    assign sta_i  = r_sta[ci];
    assign i_lt_n = r_i < i_n;
    assign absgap = (tgt_i >= cur_i) ? (tgt_i - cur_i) : (cur_i - tgt_i);
    assign dneg   = tgt_i < sta_i;
    assign mag    = dneg ? (sta_i - tgt_i) : (tgt_i - sta_i);
    assign prod   = {16'd0, mag} * {8'd0, r_idx};
    assign min_iv = (i_cfg.min_iv == 10'd0) ? 16'd1 : {6'd0, i_cfg.min_iv};
    assign tick_n = r_tick + 16'd1;
    assign nv_add = {2'd0, sta_i} + {2'd0, i_div_quo[7:0]};
    assign nv_sub = {2'd0, sta_i} - {2'd0, i_div_quo[7:0]};
    assign master = (i_n != '0) ? r_cur[0] : 8'd0;

    always_comb begin
        if (r_neg) begin
            nv = nv_sub[9] ? 8'd0 : nv_sub[7:0];
        end else begin
            nv = (nv_add[9:8] != 2'd0) ? mlfe_pkg::LEVEL_MAX : nv_add[7:0];
        end
    end

    // Light channels that the parameter leaves out read as zero
    always_comb begin
        for (int j = 0; j < 5; j++) begin
            cur_pad[j] = 8'd0;
            if (j < NUM_CHANNELS) begin
                cur_pad[j] = r_cur[j % NUM_CHANNELS];
            end
        end
        for (int k = 0; k < 4; k++) begin
            x_pwm[k] = {8'd0, cur_pad[k+1]} * {8'd0, i_cfg.calib[k]};
        end
    end

    // Divide by 255: estimate, then one correction step
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            q0s      = ({1'b0, r_x[k]} + {9'd0, r_x[k][15:8]}) >> 8;
            q0       = q0s[7:0];
            rem      = {1'b0, r_x[k]} - {1'b0, q0, 8'd0} + {9'd0, q0};
            y_pwm[k] = (rem >= 17'd255) ? (q0 + 8'd1) : q0;
        end
    end

    // Hold the next request while the last result is still on its way out
    assign o_cmd_pop = (r_state == S_IDLE) && i_cmd_vld && !i_out_full && !r_res_vld;
    assign o_div_req = r_div_req;
    assign o_res_vld = r_res_vld;
    assign o_res     = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_idx           <= 16'd0;
            r_total         <= 16'd0;
            r_iv            <= 16'd0;
            r_tick          <= 16'd0;
            r_run           <= 1'b0;
            r_res_vld       <= 1'b0;
            r_div_req.start <= 1'b0;
            for (int j = 0; j < NUM_CHANNELS; j++) begin
                r_cur[j] <= 8'd0;
                r_tgt[j] <= 8'd0;
                r_sta[j] <= 8'd0;
            end
        end else begin
            r_div_req.start <= 1'b0;
            r_res_vld       <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (o_cmd_pop) begin
                        r_chg <= 1'b0;
                        r_i   <= '0;
                        r_gap <= 8'd0;
                        case (i_cmd.kind)
                            mlfe_pkg::CMD_TARGET: begin
                                r_tgt[ch_idx] <= i_cmd.level;
                                r_state       <= S_SCAN;
                            end
                            mlfe_pkg::CMD_TICK: begin
                                if (!r_run) begin
                                    r_state <= S_PWM_MUL;
                                end else if (tick_n >= r_iv) begin
                                    r_tick <= 16'd0;
                                    r_idx  <= r_idx + 16'd1;
                                    if (r_total == 16'd0) begin
                                        r_total <= 16'd1;
                                    end
                                    r_state <= S_CH;
                                end else begin
                                    r_tick  <= tick_n;
                                    r_state <= S_PWM_MUL;
                                end
                            end
                            default: begin
                                r_state <= S_PWM_MUL;
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    if (i_lt_n) begin
                        if (absgap > r_gap) begin
                            r_gap <= absgap;
                        end
                        r_i <= r_i + 1'b1;
                    end else if (r_gap == 8'd0) begin
                        r_state <= S_PWM_MUL;
                    end else begin
                        for (int j = 0; j < NUM_CHANNELS; j++) begin
                            if (j < int'(i_n)) begin
                                r_sta[j] <= r_cur[j];
                            end
                        end
                        r_div_req.start <= 1'b1;
                        r_div_req.rem0  <= 16'd0;
                        r_div_req.dnd   <= i_cfg.duration;
                        r_div_req.den   <= {8'd0, r_gap};
                        r_div_req.steps <= 5'd16;
                        r_state         <= S_DIV_PER;
                    end
                end
                S_DIV_PER: begin
                    if (i_div_done) begin
                        if (i_div_quo < min_iv) begin
                            r_iv            <= min_iv;
                            r_div_req.start <= 1'b1;
                            r_div_req.rem0  <= 16'd0;
                            r_div_req.dnd   <= i_cfg.duration;
                            r_div_req.den   <= min_iv;
                            r_div_req.steps <= 5'd16;
                            r_state         <= S_DIV_TOT;
                        end else begin
                            r_iv    <= i_div_quo;
                            r_total <= {8'd0, r_gap};
                            r_idx   <= 16'd0;
                            r_tick  <= 16'd0;
                            r_run   <= 1'b1;
                            r_state <= S_PWM_MUL;
                        end
                    end
                end
                S_DIV_TOT: begin
                    if (i_div_done) begin
                        r_total <= (i_div_quo == 16'd0) ? 16'd1 : i_div_quo;
                        r_idx   <= 16'd0;
                        r_tick  <= 16'd0;
                        r_run   <= 1'b1;
                        r_state <= S_PWM_MUL;
                    end
                end
                S_CH: begin
                    if (!i_lt_n) begin
                        if (r_idx >= r_total) begin
                            r_run <= 1'b0;
                        end
                        r_state <= S_PWM_MUL;
                    end else if (cur_i == tgt_i) begin
                        r_i <= r_i + 1'b1;
                    end else begin
                        // Quotient stays below 256 since step index never passes total
                        r_neg           <= dneg;
                        r_div_req.start <= 1'b1;
                        r_div_req.rem0  <= prod[23:8];
                        r_div_req.dnd   <= {prod[7:0], 8'd0};
                        r_div_req.den   <= r_total;
                        r_div_req.steps <= 5'd8;
                        r_state         <= S_CDIV;
                    end
                end
                S_CDIV: begin
                    if (i_div_done) begin
                        if (nv != cur_i) begin
                            r_cur[ci] <= nv;
                            r_chg     <= 1'b1;
                        end
                        r_i     <= r_i + 1'b1;
                        r_state <= S_CH;
                    end
                end
                S_PWM_MUL: begin
                    for (int k = 0; k < 4; k++) begin
                        r_x[k] <= x_pwm[k];
                    end
                    r_state <= S_PWM_DIV;
                end
                S_PWM_DIV: begin
                    for (int k = 0; k < 4; k++) begin
                        r_y[k] <= y_pwm[k];
                    end
                    r_state <= S_PWM_OUT;
                end
                S_PWM_OUT: begin
                    r_res.pwm_one   <= (int'(i_n) > 1) ? 15'(({8'd0, r_y[0]} * {8'd0, master}) >> 1)
                                                       : 15'd0;
                    r_res.pwm_two   <= (int'(i_n) > 2) ? 15'(({8'd0, r_y[1]} * {8'd0, master}) >> 1)
                                                       : 15'd0;
                    r_res.pwm_three <= (int'(i_n) > 3) ? 15'(({8'd0, r_y[2]} * {8'd0, master}) >> 1)
                                                       : 15'd0;
                    r_res.pwm_four  <= (int'(i_n) > 4) ? 15'(({8'd0, r_y[3]} * {8'd0, master}) >> 1)
                                                       : 15'd0;
                    r_res.master_now      <= master;
                    r_res.fading          <= r_run;
                    r_res.outputs_changed <= r_chg;
                    r_res_vld             <= 1'b1;
                    r_state               <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: hdl/multichannel_led_fade_engine.sv
// Top level of the LED fade engine: config registers, output register, wiring.
// Depends on mlfe_pkg, mlfe_front, mlfe_div and mlfe_back.
//
// Usage:
//  - Input queue side: drive i_in_item and raise push; the request is taken at
//    a clock edge with push high and full low. A request either sets one
//    channel's target level (mode 0) or is a one-millisecond tick (mode 1).
//  - Result queue side: while empty is low, o_out_item holds the oldest result;
//    raise pop to take it. Every request yields exactly one result.
//  - Config side: cfg_valid with i_cfg_index and i_cfg_data; cfg_ready is
//    always high. Write only while no request is in flight.
//  - Sequence: a tick without a step or an ignored write goes straight to
//    the PWM states. A target write scans the channels (one per cycle) and,
//    if any channel must move, runs one or two divides. A fade step runs a
//    divide for each moving channel, then the PWM states.
//  - Throughput: one request at a time through the sequencer; the shared
//    divider sets the pace. A 2-entry front queue takes requests meanwhile.
//  - Stall: when the result is not popped, the sequencer holds and the front
//    queue fills, then full rises.
//  - Reset: all levels, fade state and queues clear; config returns to its
//    reset values (1000 ms, 10 ms, 5 channels, calibration 255).
module multichannel_led_fade_engine #(
    parameter int NUM_CHANNELS = 5
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  mlfe_pkg::t_in_item  i_in_item,
    output logic                empty,
    input  logic                pop,
    output mlfe_pkg::t_out_item o_out_item,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          i_cfg_index,
    input  logic [15:0]         i_cfg_data
);

    localparam int IW = $clog2(NUM_CHANNELS + 1);

    mlfe_pkg::t_cfg      r_cfg;
    logic [2:0]          r_chan_count;
    logic [IW-1:0]       act_n;
    logic                cmd_vld;
    mlfe_pkg::t_cmd      cmd;
    logic                cmd_pop;
    mlfe_pkg::t_div_req  div_req;
    logic                div_done;
    logic [15:0]         div_quo;
    logic                res_vld;
    mlfe_pkg::t_out_item res;
    logic                r_out_vld;
    mlfe_pkg::t_out_item r_out;

    assign cfg_ready = 1'b1;

    // Active channel count, limited to what the build provides
    assign act_n = (int'(r_chan_count) < NUM_CHANNELS) ? IW'(r_chan_count)
                                                        : IW'(NUM_CHANNELS);

    // Config registers; short fade durations are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.duration <= mlfe_pkg::DURATION_RESET;
            r_cfg.min_iv   <= mlfe_pkg::MIN_IV_RESET;
            r_cfg.calib    <= {4{mlfe_pkg::LEVEL_MAX}};
            r_chan_count   <= mlfe_pkg::CHAN_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (i_cfg_index)
                mlfe_pkg::REG_DURATION: begin
                    if (i_cfg_data > mlfe_pkg::DURATION_FLOOR) begin
                        r_cfg.duration <= i_cfg_data;
                    end
                end
                mlfe_pkg::REG_MIN_IV:     r_cfg.min_iv   <= i_cfg_data[9:0];
                mlfe_pkg::REG_CHAN_COUNT: r_chan_count   <= i_cfg_data[2:0];
                mlfe_pkg::REG_CALIB_ONE:  r_cfg.calib[0] <= i_cfg_data[7:0];
                mlfe_pkg::REG_CALIB_TWO:  r_cfg.calib[1] <= i_cfg_data[7:0];
                mlfe_pkg::REG_CALIB_THR:  r_cfg.calib[2] <= i_cfg_data[7:0];
                mlfe_pkg::REG_CALIB_FOUR: r_cfg.calib[3] <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    mlfe_front #(
        .IW(IW)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .push      (push),
        .full      (full),
        .i_in_item (i_in_item),
        .i_n       (act_n),
        .o_cmd_vld (cmd_vld),
        .o_cmd     (cmd),
        .i_cmd_pop (cmd_pop)
    );

    mlfe_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    mlfe_back #(
        .NUM_CHANNELS(NUM_CHANNELS),
        .IW          (IW)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd_vld  (cmd_vld),
        .i_cmd      (cmd),
        .o_cmd_pop  (cmd_pop),
        .i_cfg      (r_cfg),
        .i_n        (act_n),
        .o_div_req  (div_req),
        .i_div_done (div_done),
        .i_div_quo  (div_quo),
        .i_out_full (r_out_vld),
        .o_res_vld  (res_vld),
        .o_res      (res)
    );

    // Result register; the sequencer only fills it when empty
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (res_vld) begin
            r_out_vld <= 1'b1;
            r_out     <= res;
        end else if (pop && r_out_vld) begin
            r_out_vld <= 1'b0;
        end
    end

    assign empty      = !r_out_vld;
    assign o_out_item = r_out;

endmodule

FILE: hdl/mlfe_checker.sv
// Port-level checks of the LED fade engine, bound to the top level.
// Depends on mlfe_pkg and multichannel_led_fade_engine.
module mlfe_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                full,
    input logic                empty,
    input logic                pop,
    input mlfe_pkg::t_out_item o_out_item
);

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result queue not empty after reset");

    a_reset_not_full: assert property (@(posedge i_clk) !i_rst_n |=> !full)
        else $error("input queue full after reset");

    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_out_item)))
        else $error("waiting result changed or dropped");

    a_pwm_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_out_item.pwm_one <= 15'd32512 && o_out_item.pwm_two <= 15'd32512 &&
                    o_out_item.pwm_three <= 15'd32512 && o_out_item.pwm_four <= 15'd32512))
        else $error("pwm value out of range");

endmodule

bind multichannel_led_fade_engine mlfe_checker u_mlfe_checker (.*);
